@@ hdl/sfr_pkg.sv @@
package sfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_HUNT    = 3'd0;
  localparam logic [PhaseW-1:0] PH_LENGTH  = 3'd1;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd2;
  localparam logic [PhaseW-1:0] PH_CHECK   = 3'd3;
  localparam logic [PhaseW-1:0] PH_END     = 3'd4;

  // Configuration register indexes
  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  localparam logic [ByteW-1:0] START_RESET = 8'h02;
  localparam logic [ByteW-1:0] END_RESET   = 8'h03;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_ACCEPT    = 2'd1,
    KIND_CHECK_ERR = 2'd2,
    KIND_BAD_END   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] start_mark;
    logic [ByteW-1:0] end_mark;
  } cfg_t;

  typedef struct packed {
    logic             vld;
    kind_e            kind;
    logic [ByteW-1:0] data;
  } result_t;

endpackage

@@ hdl/sfr_cfg_regs.sv @@
module sfr_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [sfr_pkg::ByteW-1:0] cfg_data_i,
  output sfr_pkg::cfg_t            cfg_o
);

  sfr_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        sfr_pkg::CFG_START_MARKER: cfg_d.start_mark = cfg_data_i;
        sfr_pkg::CFG_END_MARKER:   cfg_d.end_mark   = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mark <= sfr_pkg::START_RESET;
      cfg_q.end_mark   <= sfr_pkg::END_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/sfr_parser.sv @@
module sfr_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [sfr_pkg::ByteW-1:0] rx_byte_i,
  input  sfr_pkg::cfg_t             cfg_i,
  output sfr_pkg::result_t          res_o
);

  logic [sfr_pkg::PhaseW-1:0] phase_d, phase_q;
  logic [sfr_pkg::ByteW-1:0]  len_d, len_q;
  logic [sfr_pkg::ByteW-1:0]  seen_d, seen_q;
  logic [sfr_pkg::ByteW-1:0]  xor_d, xor_q;
  logic [sfr_pkg::ByteW-1:0]  check_d, check_q;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    xor_d   = xor_q;
    check_d = check_q;
    res_o   = '{vld: 1'b0, kind: sfr_pkg::KIND_PAYLOAD, data: '0};
    if (step_i) begin
      case (phase_q)
        sfr_pkg::PH_HUNT: begin
          if (rx_byte_i == cfg_i.start_mark) begin
            phase_d = sfr_pkg::PH_LENGTH;
            seen_d  = '0;
            xor_d   = '0;
          end
        end
        sfr_pkg::PH_LENGTH: begin
          len_d   = rx_byte_i;
          seen_d  = '0;
          xor_d   = '0;
          // empty frame goes straight to the checksum byte
          phase_d = (rx_byte_i == '0) ? sfr_pkg::PH_CHECK : sfr_pkg::PH_PAYLOAD;
        end
        sfr_pkg::PH_PAYLOAD: begin
          xor_d  = xor_q ^ rx_byte_i;
          seen_d = seen_q + 1'b1;
          if (seen_d == len_q) begin
            phase_d = sfr_pkg::PH_CHECK;
          end
          res_o = '{vld: 1'b1, kind: sfr_pkg::KIND_PAYLOAD, data: rx_byte_i};
        end
        sfr_pkg::PH_CHECK: begin
          check_d = rx_byte_i;
          phase_d = sfr_pkg::PH_END;
        end
        sfr_pkg::PH_END: begin
          phase_d = sfr_pkg::PH_HUNT;
          // bad end byte wins over the checksum verdict
          if (rx_byte_i != cfg_i.end_mark) begin
            res_o = '{vld: 1'b1, kind: sfr_pkg::KIND_BAD_END, data: len_q};
          end else if (xor_q == check_q) begin
            res_o = '{vld: 1'b1, kind: sfr_pkg::KIND_ACCEPT, data: len_q};
          end else begin
            res_o = '{vld: 1'b1, kind: sfr_pkg::KIND_CHECK_ERR, data: len_q};
          end
        end
        default: begin
          phase_d = sfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfr_pkg::PH_HUNT;
      len_q   <= '0;
      seen_q  <= '0;
      xor_q   <= '0;
      check_q <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      xor_q   <= xor_d;
      check_q <= check_d;
    end
  end

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == sfr_pkg::PH_PAYLOAD |-> seen_q < len_q)
    else $error("payload count reached frame length without leaving payload phase");

  a_payload_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == sfr_pkg::PH_PAYLOAD |->
      res_o.vld && res_o.kind == sfr_pkg::KIND_PAYLOAD && res_o.data == rx_byte_i)
    else $error("payload byte not forwarded");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == sfr_pkg::PH_LENGTH && rx_byte_i == '0 |=>
      phase_q == sfr_pkg::PH_CHECK && xor_q == '0)
    else $error("zero length frame did not skip to checksum");

  a_verdict_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == sfr_pkg::PH_END |=> phase_q == sfr_pkg::PH_HUNT)
    else $error("verdict did not return to hunting");

endmodule

@@ hdl/sfr_out_stage.sv @@
module sfr_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  sfr_pkg::result_t          res_i,
  input  logic                      out_ready_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  output logic [1:0]                kind_o,
  output logic [sfr_pkg::ByteW-1:0] data_o
);

  logic                      vld_d, vld_q;
  sfr_pkg::kind_e            kind_q;
  logic [sfr_pkg::ByteW-1:0] data_q;

  // slot is free when empty or being drained this cycle
  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = res_i.vld;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.vld) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;

endmodule

@@ hdl/stx_etx_frame_receiver.sv @@
// Byte-stream frame receiver: start marker, length, payload, XOR checksum, end marker.
// Path: each accepted byte is held in the input register, and its result, if any, is then
// loaded into the result register once that register is free.
// Throughput: one byte per cycle while the result side is ready; a waiting result stalls
// the input register, also for a byte that gives no result.
// Reset (asynchronous, active low): hunting, markers 0x02 / 0x03, both stages empty.
module stx_etx_frame_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [sfr_pkg::ByteW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sfr_pkg::ByteW-1:0] rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic [sfr_pkg::ByteW-1:0] data_o
);

  sfr_pkg::cfg_t             cfg;
  sfr_pkg::result_t          res;
  logic                      in_vld_d, in_vld_q;
  logic [sfr_pkg::ByteW-1:0] byte_q;
  logic                      out_free;
  logic                      step;

  sfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // advance the held byte when the result register can take its outcome
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  sfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  sfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .data_o      (data_o)
  );

endmodule
